// ===== hw/rtl/ffc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffc_pkg
// Shared types and constants for the Fletcher-8 frame checker.
// ----------------------------------------------------------------------------
package ffc_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h65;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned RES_W  = 1 + 2 + LEN_W;
  localparam int unsigned OUT_W  = ((RES_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_BAD_SUM  = 2'd2
  } status_t;

  typedef struct packed {
    logic [LEN_W-1:0] payload_length;
    status_t          status;
    logic             frame_ok;
  } res_t;

endpackage

// ===== hw/rtl/ffc_parser.sv =====
// ----------------------------------------------------------------------------
// ffc_parser
// Frame parse state, Fletcher-8 sums and verdict generation, one byte a step.
// ----------------------------------------------------------------------------
module ffc_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [ffc_pkg::BYTE_W-1:0]    step_byte,
  input  logic                          step_first,
  output logic                          res_vld,
  output ffc_pkg::res_t                 res
);

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_TYPE    = 8'b0000_0010,
    PH_LEN_LO  = 8'b0000_0100,
    PH_LEN_HI  = 8'b0000_1000,
    PH_PAYLOAD = 8'b0001_0000,
    PH_CHECK_A = 8'b0010_0000,
    PH_CHECK_B = 8'b0100_0000,
    PH_DONE    = 8'b1000_0000
  } phase_t;

  phase_t                       phase_r,   phase_nxt;
  logic [ffc_pkg::LEN_W-1:0]    len_r,     len_nxt;
  logic [ffc_pkg::LEN_W-1:0]    left_r,    left_nxt;
  logic [ffc_pkg::BYTE_W-1:0]   sum_a_r,   sum_a_nxt;
  logic [ffc_pkg::BYTE_W-1:0]   sum_b_r,   sum_b_nxt;
  logic [ffc_pkg::BYTE_W-1:0]   chk_a_r,   chk_a_nxt;
  logic [ffc_pkg::BYTE_W-1:0]   acc_a;
  logic [ffc_pkg::BYTE_W-1:0]   acc_b;
  logic [ffc_pkg::LEN_W-1:0]    len_full;
  logic                         sum_ok;

  assign acc_a    = sum_a_r + step_byte;
  assign acc_b    = sum_b_r + acc_a;
  assign len_full = {step_byte, len_r[ffc_pkg::BYTE_W-1:0]};
  assign sum_ok   = (chk_a_r == sum_a_r) && (step_byte == sum_b_r);

  always_comb begin
    phase_nxt          = phase_r;
    len_nxt            = len_r;
    left_nxt           = left_r;
    sum_a_nxt          = sum_a_r;
    sum_b_nxt          = sum_b_r;
    chk_a_nxt          = chk_a_r;
    res_vld            = 1'b0;
    res.frame_ok       = 1'b0;
    res.status         = ffc_pkg::ST_BAD_SYNC;
    res.payload_length = '0;
    if (step) begin
      if (step_first) begin
        sum_a_nxt = '0;
        sum_b_nxt = '0;
        len_nxt   = '0;
        left_nxt  = '0;
        chk_a_nxt = '0;
        if (step_byte != ffc_pkg::SYNC_BYTE) begin
          phase_nxt = PH_DONE;
          res_vld   = 1'b1;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end else begin
        unique case (phase_r)
          PH_TYPE: begin
            sum_a_nxt = acc_a;
            sum_b_nxt = acc_b;
            phase_nxt = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            sum_a_nxt = acc_a;
            sum_b_nxt = acc_b;
            len_nxt   = {{(ffc_pkg::LEN_W-ffc_pkg::BYTE_W){1'b0}}, step_byte};
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            sum_a_nxt = acc_a;
            sum_b_nxt = acc_b;
            len_nxt   = len_full;
            left_nxt  = len_full;
            phase_nxt = (len_full == '0) ? PH_CHECK_A : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            sum_a_nxt = acc_a;
            sum_b_nxt = acc_b;
            left_nxt  = left_r - 1'b1;
            if (left_r == ffc_pkg::LEN_W'(1)) begin
              phase_nxt = PH_CHECK_A;
            end
          end
          PH_CHECK_A: begin
            chk_a_nxt = step_byte;
            phase_nxt = PH_CHECK_B;
          end
          PH_CHECK_B: begin
            phase_nxt          = PH_DONE;
            res_vld            = 1'b1;
            res.frame_ok       = sum_ok;
            res.status         = sum_ok ? ffc_pkg::ST_OK : ffc_pkg::ST_BAD_SUM;
            res.payload_length = len_r;
          end
          PH_IDLE, PH_DONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      left_r  <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      chk_a_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      chk_a_r <= chk_a_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> (phase_r == PH_DONE))
    else $error("parser not done after verdict");

  a_bad_sync_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && (res.status == ffc_pkg::ST_BAD_SYNC)) |->
      ((res.payload_length == '0) && !res.frame_ok))
    else $error("bad sync verdict carries length or ok");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (left_r != '0))
    else $error("payload phase with no bytes left");
`endif

endmodule

// ===== hw/rtl/ffc_out_stage.sv =====
// ----------------------------------------------------------------------------
// ffc_out_stage
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module ffc_out_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_vld,
  input  ffc_pkg::res_t               res,
  output logic                        advance,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ffc_pkg::OUT_W-1:0]   out_tdata
);

  logic          vld_r;
  ffc_pkg::res_t data_r;

  assign advance    = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {{(ffc_pkg::OUT_W-ffc_pkg::RES_W){1'b0}}, data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      data_r <= res;
    end
  end

endmodule

// ===== hw/rtl/frame_fletcher_checker.sv =====
// A byte's verdict is formed combinationally and held in the result register.
// Throughput: one byte per cycle when not stalled; both registers run back to back.
// Stalls come only from the result register when out_tready is low with a verdict held.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// idle, so bytes are ignored until one arrives with the first flag.
// ----------------------------------------------------------------------------
// frame_fletcher_checker
// Checks sync byte and Fletcher-8 check bytes of framed messages, one byte per request.
// ----------------------------------------------------------------------------
module frame_fletcher_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ffc_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                        in_tuser,   // [0] first_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ffc_pkg::OUT_W-1:0]   out_tdata   // [0] frame_ok, [2:1] status,
                                                  // [18:3] payload_length, rest 0
);

  logic                         in_vld_r;
  logic [ffc_pkg::BYTE_W-1:0]   in_byte_r;
  logic                         in_first_r;
  logic                         advance;
  logic                         step;
  logic                         res_vld;
  ffc_pkg::res_t                res;

  assign step      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
    end
  end

  ffc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .step_byte  (in_byte_r),
    .step_first (in_first_r),
    .res_vld    (res_vld),
    .res        (res)
  );

  ffc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_fletcher_checker.
// Drives framed byte streams (good frames, bad check bytes, bad sync, cut
// frames, stray bytes) with random gaps and result stalls, tracks the parser
// in a local frame tracker and compares every verdict field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    P_IDLE, P_TYPE, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CHECK_A, P_CHECK_B, P_DONE
  } parse_phase_t;

  typedef enum int {
    FAULT_NONE, FAULT_CHECK_A, FAULT_CHECK_B, FAULT_CUT
  } frame_fault_t;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic [ffc_pkg::BYTE_W-1:0]   in_tdata   = '0;
  logic                         in_tuser   = 1'b0;
  logic                         out_tready = 1'b0;
  wire                          in_tready;
  wire                          out_tvalid;
  wire  [ffc_pkg::OUT_W-1:0]    out_tdata;

  ffc_pkg::res_t verdict_q[$];
  int   errors       = 0;
  bit   src_idle_en  = 1'b1;
  bit   sink_idle_en = 1'b1;
  int   sink_hold    = 0;

  // frame tracker state
  parse_phase_t  trk_phase   = P_IDLE;
  logic [15:0]   trk_len     = '0;
  logic [15:0]   trk_left    = '0;
  logic [7:0]    trk_sum_a   = '0;
  logic [7:0]    trk_sum_b   = '0;
  logic [7:0]    trk_check_a = '0;

  frame_fletcher_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic first);
    ffc_pkg::res_t r;
    bit            hit;
    r   = '0;
    hit = 1'b0;
    if (first) begin
      trk_sum_a   = '0;
      trk_sum_b   = '0;
      trk_len     = '0;
      trk_left    = '0;
      trk_check_a = '0;
      if (b != ffc_pkg::SYNC_BYTE) begin
        trk_phase = P_DONE;
        r.status  = ffc_pkg::ST_BAD_SYNC;
        hit       = 1'b1;
      end else begin
        trk_phase = P_TYPE;
      end
    end else begin
      if (trk_phase >= P_TYPE && trk_phase <= P_PAYLOAD) begin
        trk_sum_a = trk_sum_a + b;
        trk_sum_b = trk_sum_b + trk_sum_a;
      end
      case (trk_phase)
        P_TYPE: trk_phase = P_LEN_LO;
        P_LEN_LO: begin
          trk_len   = {8'h00, b};
          trk_phase = P_LEN_HI;
        end
        P_LEN_HI: begin
          trk_len   = {b, trk_len[7:0]};
          trk_left  = trk_len;
          trk_phase = (trk_len == 16'd0) ? P_CHECK_A : P_PAYLOAD;
        end
        P_PAYLOAD: begin
          trk_left = trk_left - 16'd1;
          if (trk_left == 16'd0) trk_phase = P_CHECK_A;
        end
        P_CHECK_A: begin
          trk_check_a = b;
          trk_phase   = P_CHECK_B;
        end
        P_CHECK_B: begin
          r.frame_ok       = (trk_check_a == trk_sum_a) && (b == trk_sum_b);
          r.status         = r.frame_ok ? ffc_pkg::ST_OK : ffc_pkg::ST_BAD_SUM;
          r.payload_length = trk_len;
          trk_phase        = P_DONE;
          hit              = 1'b1;
        end
        default: ;
      endcase
    end
    if (hit) verdict_q.push_back(r);
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    track_byte(b, first);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input int len, input frame_fault_t fault);
    logic [7:0] body[$];
    logic [7:0] a;
    logic [7:0] b;
    int         cut;
    a = '0;
    b = '0;
    body.push_back(ftype);
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    repeat (len) body.push_back(8'($urandom_range(255)));
    foreach (body[i]) begin
      a = a + body[i];
      b = b + a;
    end
    body.push_back((fault == FAULT_CHECK_A) ? (a ^ 8'($urandom_range(255, 1))) : a);
    body.push_back((fault == FAULT_CHECK_B) ? (b ^ 8'($urandom_range(255, 1))) : b);
    cut = (fault == FAULT_CUT) ? $urandom_range(body.size() - 1) : body.size();
    send_byte(ffc_pkg::SYNC_BYTE, 1'b1);
    for (int i = 0; i < cut; i++) send_byte(body[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_bad_sync();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == ffc_pkg::SYNC_BYTE) b = b ^ 8'h01;
    send_byte(b, 1'b1);
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0);               // before any first flag
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);               // bad sync
    send_byte(ffc_pkg::SYNC_BYTE, 1'b0);  // ignored, no flag
    send_frame(8'hFF, 0, FAULT_NONE);     // empty payload
    send_byte(8'h00, 1'b0);               // after verdict
    send_frame(8'h00, 0, FAULT_CHECK_A);
    send_byte(ffc_pkg::SYNC_BYTE, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(ffc_pkg::SYNC_BYTE ^ 8'h01, 1'b1);   // restart mid-frame with bad sync
    send_frame(8'h80, 1, FAULT_CHECK_B);
    wait_drained();
  endtask

  task automatic test_max_length();
    src_idle_en = 1'b0;
    // full-scale length header, cut short by the next frame
    send_byte(ffc_pkg::SYNC_BYTE, 1'b1);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (10) send_byte(8'($urandom_range(255)), 1'b0);
    send_frame(8'($urandom_range(255)), 256, FAULT_NONE);
    src_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < 280) begin
      src_idle_en  = !(sent >= 100 && sent < 180);
      sink_idle_en = !(sent >= 100 && sent < 180);
      pick = $urandom_range(99);
      len  = ($urandom_range(29) == 0) ? $urandom_range(300, 9) : $urandom_range(8);
      if (pick < 70) begin
        send_frame(8'($urandom_range(255)), len, FAULT_NONE);
        sent += len + 6;
      end else if (pick < 80) begin
        send_frame(8'($urandom_range(255)), len,
                   pick[0] ? FAULT_CHECK_A : FAULT_CHECK_B);
        sent += len + 6;
      end else if (pick < 87) begin
        send_frame(8'($urandom_range(255)), len, FAULT_CUT);
        sent += 3;
      end else if (pick < 93) begin
        send_bad_sync();
        sent += 1;
      end else begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    wait_drained();
  endtask

  task automatic test_result_stall();
    src_idle_en = 1'b0;
    repeat (30) begin
      if ($urandom_range(3) == 0) send_bad_sync();
      else send_frame(8'($urandom_range(255)), $urandom_range(1), FAULT_NONE);
    end
    src_idle_en = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (sink_idle_en) sink_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    ffc_pkg::res_t got;
    ffc_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = ffc_pkg::res_t'(out_tdata[ffc_pkg::RES_W-1:0]);
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, actual tdata %h", $time, out_tdata);
      end else begin
        want = verdict_q.pop_front();
        if (got.frame_ok !== want.frame_ok) begin
          errors++;
          $display("%0t: frame_ok expected %0b actual %0b", $time,
                   want.frame_ok, got.frame_ok);
        end
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.payload_length !== want.payload_length) begin
          errors++;
          $display("%0t: payload_length expected %0d actual %0d", $time,
                   want.payload_length, got.payload_length);
        end
        if (out_tdata[ffc_pkg::OUT_W-1:ffc_pkg::RES_W] !== '0) begin
          errors++;
          $display("%0t: tdata pad expected 0 actual %h", $time,
                   out_tdata[ffc_pkg::OUT_W-1:ffc_pkg::RES_W]);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_max_length();
    test_random();
    test_result_stall();
    wait_drained();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ffc_pkg.sv
hw/rtl/ffc_parser.sv
hw/rtl/ffc_out_stage.sv
hw/rtl/frame_fletcher_checker.sv
tb/sv/tb.sv
